// ----- sv/homogeneous_line_clip_assert.svh -----
// Assertion macros for the homogeneous line clipper.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef HOMOGENEOUS_LINE_CLIP_ASSERT_SVH
`define HOMOGENEOUS_LINE_CLIP_ASSERT_SVH
`ifndef SYNTH
`define HLC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hlc assertion failed");
`define HLC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `HLC_ASSERT(lbl, clk, rstn, !(cond))
`else
`define HLC_ASSERT(lbl, clk, rstn, prop)
`define HLC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- sv/hlc_pkg.sv -----
// Shared constants, word types and helpers of the homogeneous line clipper.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hlc_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int NumPlanes  = 6;
  localparam int NumAxes    = 4;
  // boundary values w +/- c and coordinate differences
  localparam int BndW = CoordWidth + 1;
  // numerator, denominator and remainder of the plane quotients
  localparam int DenW = CoordWidth + 2;
  // t in unsigned Q1.FracBits, 0 to 1 inclusive
  localparam int TW   = FracBits + 1;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [NumAxes-1:0][CoordWidth-1:0] vec_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t a_w;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t b_w;
  } in_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_a_x;
    coord_t clip_a_y;
    coord_t clip_a_z;
    coord_t clip_a_w;
    coord_t clip_b_x;
    coord_t clip_b_y;
    coord_t clip_b_z;
    coord_t clip_b_w;
  } out_t;

  // word traveling through the divider stages
  typedef struct packed {
    in_t                                   pts;
    logic [NumPlanes-1:0]                  exit_m;
    logic [NumPlanes-1:0]                  ent_m;
    logic                                  rej;
    logic                                  triv;
    logic                                  a_out;
    logic                                  b_out;
    logic [NumAxes-1:0]                    d_neg;
    logic [NumAxes-1:0][BndW-1:0]          d_mag;
    logic [NumPlanes-1:0][DenW-1:0]        rem;
    logic [NumPlanes-1:0][DenW-1:0]        den;
    logic [NumPlanes-1:0][FracBits-1:0]    quo;
  } div_t;

  // axes in order x, y, z, w
  function automatic vec_t a_vec(input in_t p);
    vec_t v;
    v[0] = p.a_x;
    v[1] = p.a_y;
    v[2] = p.a_z;
    v[3] = p.a_w;
    return v;
  endfunction

  function automatic vec_t b_vec(input in_t p);
    vec_t v;
    v[0] = p.b_x;
    v[1] = p.b_y;
    v[2] = p.b_z;
    v[3] = p.b_w;
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hlc_bound.sv -----
// Front end: boundary values, outcodes and quotient operands (two stages).
// Depends on hlc_pkg.
`default_nettype none
module hlc_bound (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire hlc_pkg::in_t data_i,
  output logic              valid_o,
  output hlc_pkg::div_t     data_o
);

  localparam int BndW = hlc_pkg::BndW;
  localparam int DenW = hlc_pkg::DenW;
  localparam int NP   = hlc_pkg::NumPlanes;
  localparam int NA   = hlc_pkg::NumAxes;

  logic                   s1_valid_q;
  hlc_pkg::in_t           s1_pts_q;
  logic signed [BndW-1:0] s1_ba_q [NP];
  logic signed [BndW-1:0] s1_bb_q [NP];
  logic signed [BndW-1:0] s1_d_q  [NA];
  logic signed [BndW-1:0] ba_d [NP];
  logic signed [BndW-1:0] bb_d [NP];
  logic signed [BndW-1:0] d_d  [NA];

  logic          s2_valid_q;
  hlc_pkg::div_t s2_q, s2_d;

  always_comb begin
    hlc_pkg::vec_t av, bv;
    av = hlc_pkg::a_vec(data_i);
    bv = hlc_pkg::b_vec(data_i);
    // planes: w+x, w-x, w+y, w-y, w+z, w-z
    for (int k = 0; k < 3; k++) begin
      ba_d[2*k]   = BndW'($signed(av[3])) + BndW'($signed(av[k]));
      ba_d[2*k+1] = BndW'($signed(av[3])) - BndW'($signed(av[k]));
      bb_d[2*k]   = BndW'($signed(bv[3])) + BndW'($signed(bv[k]));
      bb_d[2*k+1] = BndW'($signed(bv[3])) - BndW'($signed(bv[k]));
    end
    for (int j = 0; j < NA; j++) begin
      d_d[j] = BndW'($signed(bv[j])) - BndW'($signed(av[j]));
    end
  end

  always_comb begin
    logic [NP-1:0] oa, ob;
    logic signed [DenW-1:0] bae, bbe;
    s2_d      = '0;
    s2_d.pts  = s1_pts_q;
    for (int i = 0; i < NP; i++) begin
      oa[i] = s1_ba_q[i][BndW-1] || (s1_ba_q[i] == '0);
      ob[i] = s1_bb_q[i][BndW-1] || (s1_bb_q[i] == '0);
      bae   = DenW'(s1_ba_q[i]);
      bbe   = DenW'(s1_bb_q[i]);
      s2_d.exit_m[i] = s1_bb_q[i][BndW-1];
      s2_d.ent_m[i]  = !s1_bb_q[i][BndW-1] && s1_ba_q[i][BndW-1];
      if (s2_d.exit_m[i]) begin
        s2_d.rem[i] = bae;
        s2_d.den[i] = bae - bbe;
      end else if (s2_d.ent_m[i]) begin
        s2_d.rem[i] = -bae;
        s2_d.den[i] = bbe - bae;
      end else begin
        s2_d.rem[i] = '0;
        s2_d.den[i] = DenW'(1);
      end
    end
    s2_d.rej   = |(oa & ob);
    s2_d.triv  = ((oa | ob) == '0);
    s2_d.a_out = |oa;
    s2_d.b_out = |ob;
    for (int j = 0; j < NA; j++) begin
      s2_d.d_neg[j] = s1_d_q[j][BndW-1];
      s2_d.d_mag[j] = s1_d_q[j][BndW-1] ? BndW'(-s1_d_q[j]) : BndW'(s1_d_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pts_q <= data_i;
      s1_ba_q  <= ba_d;
      s1_bb_q  <= bb_d;
      s1_d_q   <= d_d;
      s2_q     <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule
`default_nettype wire

// ----- sv/hlc_div_step.sv -----
// One restoring division step for all six planes, registered.
// Depends on hlc_pkg.
`default_nettype none
module hlc_div_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire hlc_pkg::div_t data_i,
  output logic               valid_o,
  output hlc_pkg::div_t      data_o
);

  localparam int DenW = hlc_pkg::DenW;
  localparam int FB   = hlc_pkg::FracBits;

  logic          valid_q;
  hlc_pkg::div_t data_q, data_d;

  always_comb begin
    logic [DenW:0] r2, dx;
    logic          ge;
    data_d = data_i;
    for (int i = 0; i < hlc_pkg::NumPlanes; i++) begin
      r2 = {data_i.rem[i], 1'b0};
      dx = {1'b0, data_i.den[i]};
      ge = (r2 >= dx);
      data_d.rem[i] = ge ? DenW'(r2 - dx) : DenW'(r2);
      data_d.quo[i] = {data_i.quo[i][FB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ----- sv/hlc_lerp.sv -----
// Back end: t selection, visibility, interpolation and saturation (four stages).
// Depends on hlc_pkg.
`default_nettype none
module hlc_lerp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire hlc_pkg::div_t data_i,
  output logic               valid_o,
  output hlc_pkg::out_t      data_o
);

  localparam int CW   = hlc_pkg::CoordWidth;
  localparam int FB   = hlc_pkg::FracBits;
  localparam int BndW = hlc_pkg::BndW;
  localparam int TW   = hlc_pkg::TW;
  localparam int NA   = hlc_pkg::NumAxes;
  localparam int HiW  = BndW - FB;
  localparam int PhW  = HiW + TW;
  localparam int PlW  = FB + TW;
  localparam int PW   = PhW + 1;
  localparam int QW   = PW + 1;
  localparam int SW   = QW + 1;

  typedef struct packed {
    hlc_pkg::in_t              pts;
    logic                      rej;
    logic                      triv;
    logic                      a_out;
    logic                      b_out;
    logic [NA-1:0]             d_neg;
    logic [NA-1:0][BndW-1:0]   d_mag;
    logic [TW-1:0]             t_in;
    logic [TW-1:0]             t_out;
  } sel_t;

  typedef struct packed {
    hlc_pkg::in_t              pts;
    logic                      vis;
    logic                      mv_a;
    logic                      mv_b;
    logic [NA-1:0]             d_neg;
    logic [NA-1:0][PhW-1:0]    ph_a;
    logic [NA-1:0][PlW-1:0]    pl_a;
    logic [NA-1:0][PhW-1:0]    ph_b;
    logic [NA-1:0][PlW-1:0]    pl_b;
  } mul_t;

  typedef struct packed {
    hlc_pkg::in_t              pts;
    logic                      vis;
    logic                      mv_a;
    logic                      mv_b;
    logic [NA-1:0][QW-1:0]     q_a;
    logic [NA-1:0][QW-1:0]     q_b;
  } off_t;

  logic          l1_valid_q, l2_valid_q, l3_valid_q, l4_valid_q;
  sel_t          l1_q, l1_d;
  mul_t          l2_q, l2_d;
  off_t          l3_q, l3_d;
  hlc_pkg::out_t l4_q, l4_d;

  function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] s);
    logic [SW-CW:0] top;
    top = s[SW-1:CW-1];
    if (top == '0 || top == '1) begin
      return s[CW-1:0];
    end
    return s[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // tighten entry and exit plane by plane
  always_comb begin
    l1_d       = '0;
    l1_d.pts   = data_i.pts;
    l1_d.rej   = data_i.rej;
    l1_d.triv  = data_i.triv;
    l1_d.a_out = data_i.a_out;
    l1_d.b_out = data_i.b_out;
    l1_d.d_neg = data_i.d_neg;
    l1_d.d_mag = data_i.d_mag;
    l1_d.t_in  = '0;
    l1_d.t_out = {1'b1, {FB{1'b0}}};
    for (int i = 0; i < hlc_pkg::NumPlanes; i++) begin
      if (data_i.exit_m[i] && ({1'b0, data_i.quo[i]} < l1_d.t_out)) begin
        l1_d.t_out = {1'b0, data_i.quo[i]};
      end
      if (data_i.ent_m[i] && ({1'b0, data_i.quo[i]} > l1_d.t_in)) begin
        l1_d.t_in = {1'b0, data_i.quo[i]};
      end
    end
  end

  always_comb begin
    logic cut;
    cut       = (l1_q.t_in > l1_q.t_out);
    l2_d      = '0;
    l2_d.pts  = l1_q.pts;
    l2_d.vis  = !l1_q.rej && (l1_q.triv || !cut);
    l2_d.mv_a = !l1_q.rej && !l1_q.triv && !cut && l1_q.a_out;
    l2_d.mv_b = !l1_q.rej && !l1_q.triv && !cut && l1_q.b_out;
    l2_d.d_neg = l1_q.d_neg;
    for (int j = 0; j < NA; j++) begin
      l2_d.ph_a[j] = PhW'(l1_q.d_mag[j][BndW-1:FB]) * PhW'(l1_q.t_in);
      l2_d.pl_a[j] = PlW'(l1_q.d_mag[j][FB-1:0]) * PlW'(l1_q.t_in);
      l2_d.ph_b[j] = PhW'(l1_q.d_mag[j][BndW-1:FB]) * PhW'(l1_q.t_out);
      l2_d.pl_b[j] = PlW'(l1_q.d_mag[j][FB-1:0]) * PlW'(l1_q.t_out);
    end
  end

  // truncate toward zero: sum magnitudes, then apply sign
  always_comb begin
    logic [PW-1:0] pa, pb;
    l3_d      = '0;
    l3_d.pts  = l2_q.pts;
    l3_d.vis  = l2_q.vis;
    l3_d.mv_a = l2_q.mv_a;
    l3_d.mv_b = l2_q.mv_b;
    for (int j = 0; j < NA; j++) begin
      pa = PW'(l2_q.ph_a[j]) + PW'(l2_q.pl_a[j] >> FB);
      pb = PW'(l2_q.ph_b[j]) + PW'(l2_q.pl_b[j] >> FB);
      l3_d.q_a[j] = l2_q.d_neg[j] ? -{1'b0, pa} : {1'b0, pa};
      l3_d.q_b[j] = l2_q.d_neg[j] ? -{1'b0, pb} : {1'b0, pb};
    end
  end

  always_comb begin
    hlc_pkg::vec_t av, bv, ra, rb;
    logic signed [SW-1:0] sa, sb;
    av = hlc_pkg::a_vec(l3_q.pts);
    bv = hlc_pkg::b_vec(l3_q.pts);
    for (int j = 0; j < NA; j++) begin
      sa = SW'($signed(av[j])) + SW'($signed(l3_q.q_a[j]));
      sb = SW'($signed(av[j])) + SW'($signed(l3_q.q_b[j]));
      ra[j] = l3_q.mv_a ? sat(sa) : av[j];
      rb[j] = l3_q.mv_b ? sat(sb) : bv[j];
    end
    l4_d.visible  = l3_q.vis;
    l4_d.clip_a_x = ra[0];
    l4_d.clip_a_y = ra[1];
    l4_d.clip_a_z = ra[2];
    l4_d.clip_a_w = ra[3];
    l4_d.clip_b_x = rb[0];
    l4_d.clip_b_y = rb[1];
    l4_d.clip_b_z = rb[2];
    l4_d.clip_b_w = rb[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_valid_q <= 1'b0;
      l2_valid_q <= 1'b0;
      l3_valid_q <= 1'b0;
      l4_valid_q <= 1'b0;
    end else if (en_i) begin
      l1_valid_q <= valid_i;
      l2_valid_q <= l1_valid_q;
      l3_valid_q <= l2_valid_q;
      l4_valid_q <= l3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q <= l1_d;
      l2_q <= l2_d;
      l3_q <= l3_d;
      l4_q <= l4_d;
    end
  end

  assign valid_o = l4_valid_q;
  assign data_o  = l4_q;

endmodule
`default_nettype wire

// ----- sv/homogeneous_line_clip.sv -----
// Homogeneous line clipper top level: pipeline and output buffer.
// Depends on hlc_pkg, hlc_bound, hlc_div_step, hlc_lerp and the assertion header.
//
// Clips a segment given as two homogeneous points against -w < x,y,z < w and
// takes one segment per clock while in_stall_o is low. The pipeline holds two
// front-end stages, one restoring division step per quotient bit for all six
// planes at once, four back-end stages and the output register. A two-entry
// output buffer absorbs a stall; in_stall_o rises only once both entries hold
// words.
`default_nettype none
`include "homogeneous_line_clip_assert.svh"
module homogeneous_line_clip (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire hlc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output hlc_pkg::out_t      out_data_o
);

  localparam int FB = hlc_pkg::FracBits;

  logic          pipe_en;
  logic          bnd_valid;
  hlc_pkg::div_t bnd_data;
  logic          div_valid [FB+1];
  hlc_pkg::div_t div_data  [FB+1];
  logic          lerp_valid;
  hlc_pkg::out_t lerp_data;

  logic          out_valid_q, skid_valid_q;
  hlc_pkg::out_t out_q, skid_q;

  // freeze the pipeline only while the spare output entry is taken
  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  hlc_bound u_bound (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (bnd_valid),
    .data_o  (bnd_data)
  );

  assign div_valid[0] = bnd_valid;
  assign div_data[0]  = bnd_data;

  for (genvar g = 0; g < FB; g++) begin : g_div
    hlc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (div_valid[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  hlc_lerp u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (div_valid[FB]),
    .data_i  (div_data[FB]),
    .valid_o (lerp_valid),
    .data_o  (lerp_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= lerp_valid;
      end
    end else if (lerp_valid) begin
      // park the word leaving the pipeline
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : lerp_data;
    end else if (pipe_en) begin
      skid_q <= lerp_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HLC_ASSERT(a_skid_has_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `HLC_ASSERT(a_skid_on_stall, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_stall_i))
  `HLC_ASSERT(a_pipe_holds, clk_i, rst_ni, !pipe_en |=> $stable(lerp_valid))

endmodule
`default_nettype wire
